// File: design/rdq_pkg.sv
// Shared types and constants for the record deque.
package rdq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int OP_W      = 3;
  localparam int KEY_W     = 30;
  localparam int PHONE_W   = 32;
  localparam int SALARY_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_LIST       = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [PHONE_W-1:0]  phone;
    logic [SALARY_W-1:0] salary;
  } rec_t;

  // Request payload
  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [KEY_W-1:0]    ssn_in;
    logic [PHONE_W-1:0]  phone_in;
    logic [SALARY_W-1:0] salary_in;
  } cmd_t;

  // Result payload
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 has_record;
    logic [KEY_W-1:0]     ssn_out;
    logic [PHONE_W-1:0]   phone_out;
    logic [SALARY_W-1:0]  salary_out;
    logic [ENTRIES_W-1:0] entries;
    logic                 last_of_run;
  } res_t;

  // Memory port strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: design/rdq_if.sv
// Valid/ready channel interfaces for requests and results.
interface rdq_cmd_if;
  logic          valid;
  logic          ready;
  rdq_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdq_res_if;
  logic          valid;
  logic          ready;
  rdq_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/record_deque_with_listing_top.sv
// Top level of the record deque: sequencer plus ring record memory.
// Push, failed pop or list, and unused opcodes: result registered the cycle after.
// Pop: result goes through the registered memory read, then the result register.
// List: as a pop, one memory read per record, one record per cycle unless stalled.
// A new request is taken after the previous run's last result, while res is free.
// Reset clears the pointers, count and result valid; the memory is not cleared.
module record_deque_with_listing_top #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rdq_cmd_if.sink   cmd,
  rdq_res_if.source res
);

  localparam int AW = $clog2(DEPTH);

  rdq_pkg::mem_ctl_t ctl;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  rdq_pkg::rec_t     wdata;
  rdq_pkg::rec_t     rdata;

  rdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .res   (res),
    .ctl   (ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rdq_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .ctl   (ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// File: design/rdq_store.sv
// Ring record memory: one write port, one registered read port.
module rdq_store #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  rdq_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rdq_pkg::rec_t            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rdq_pkg::rec_t            rdata
);

  rdq_pkg::rec_t mem [DEPTH];

  // Write on strobe, register read data on strobe
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/rdq_ctrl.sv
// Deque sequencer: ring pointers, memory requests and result register.
module rdq_ctrl #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  rdq_cmd_if.sink                  cmd,
  rdq_res_if.source                res,
  output rdq_pkg::mem_ctl_t        ctl,
  output logic [$clog2(DEPTH)-1:0] waddr,
  output rdq_pkg::rec_t            wdata,
  output logic [$clog2(DEPTH)-1:0] raddr,
  input  rdq_pkg::rec_t            rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = rdq_pkg::ENTRIES_W;

  typedef enum logic {S_IDLE, S_DATA} state_t;

  state_t            state;
  logic [AW-1:0]     front;
  logic [CW-1:0]     count;
  logic [CW-1:0]     off;
  logic              listing;
  logic              ov;
  rdq_pkg::res_t     res_q;

  logic              acc;
  logic              out_free;
  logic              full;
  logic              empty;
  logic              load;
  rdq_pkg::res_t     res_d;
  rdq_pkg::op_t      op;
  logic [AW-1:0]     front_inc;
  logic [AW-1:0]     front_dec;

  // Ring slot at a given distance from base
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] ofs);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(ofs);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  assign op        = rdq_pkg::op_t'(cmd.data.opcode);
  assign out_free  = !ov || res.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign acc       = cmd.valid && cmd.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;

  assign res.valid = ov;
  assign res.data  = res_q;

  assign wdata.key    = cmd.data.ssn_in;
  assign wdata.phone  = cmd.data.phone_in;
  assign wdata.salary = cmd.data.salary_in;

  // Memory requests and the next result
  always_comb begin
    ctl.we = 1'b0;
    ctl.re = 1'b0;
    waddr  = '0;
    raddr  = '0;
    load   = 1'b0;
    res_d  = '0;
    res_d.status      = rdq_pkg::ST_OK;
    res_d.entries     = EW'(count);
    res_d.last_of_run = 1'b1;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (op)
            rdq_pkg::OP_PUSH_BACK, rdq_pkg::OP_PUSH_FRONT: begin
              load = 1'b1;
              if (full) begin
                res_d.status = rdq_pkg::ST_FULL;
              end else begin
                ctl.we        = 1'b1;
                waddr         = (op == rdq_pkg::OP_PUSH_BACK) ? slot_at(front, count)
                                                              : front_dec;
                res_d.entries = EW'(count + 1'b1);
              end
            end
            rdq_pkg::OP_POP_BACK, rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_LIST: begin
              if (empty) begin
                load         = 1'b1;
                res_d.status = rdq_pkg::ST_EMPTY;
              end else begin
                ctl.re = 1'b1;
                raddr  = (op == rdq_pkg::OP_POP_BACK) ? slot_at(front, count - 1'b1)
                                                      : front;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_DATA: begin
        if (out_free) begin
          load              = 1'b1;
          res_d.has_record  = 1'b1;
          res_d.ssn_out     = rdata.key;
          res_d.phone_out   = rdata.phone;
          res_d.salary_out  = rdata.salary;
          res_d.last_of_run = !listing || (off == count);
          // Fetch the next listed record while this one is loaded
          if (listing && (off != count)) begin
            ctl.re = 1'b1;
            raddr  = slot_at(front, off);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Hold pointers, sequence state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      front   <= '0;
      count   <= '0;
      off     <= '0;
      listing <= 1'b0;
      ov      <= 1'b0;
    end else begin
      if (load) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (op)
              rdq_pkg::OP_PUSH_BACK: begin
                if (!full) count <= count + 1'b1;
              end
              rdq_pkg::OP_PUSH_FRONT: begin
                if (!full) begin
                  count <= count + 1'b1;
                  front <= front_dec;
                end
              end
              rdq_pkg::OP_POP_BACK: begin
                if (!empty) begin
                  count   <= count - 1'b1;
                  listing <= 1'b0;
                  state   <= S_DATA;
                end
              end
              rdq_pkg::OP_POP_FRONT: begin
                if (!empty) begin
                  count   <= count - 1'b1;
                  front   <= front_inc;
                  listing <= 1'b0;
                  state   <= S_DATA;
                end
              end
              rdq_pkg::OP_LIST: begin
                if (!empty) begin
                  off     <= CW'(1);
                  listing <= 1'b1;
                  state   <= S_DATA;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DATA: begin
          if (out_free) begin
            if (!listing || (off == count)) begin
              state <= S_IDLE;
            end else begin
              off <= off + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  // Fill level stays within the ring
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("deque count exceeds depth");

  // Never read and write the memory in one cycle
  assert property (@(posedge clk) disable iff (rst) !(ctl.we && ctl.re))
    else $error("memory read and write collide");

  // Pointers move only on an accepted request
  assert property (@(posedge clk) disable iff (rst)
                   !acc |=> ($stable(count) && $stable(front)))
    else $error("pointers moved without a request");

  // A memory read always leads to a data cycle
  assert property (@(posedge clk) disable iff (rst) ctl.re |=> (state == S_DATA))
    else $error("read data not consumed");

  // A listing never walks past the held records
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_DATA && listing) |-> (off <= count && off != '0))
    else $error("listing offset out of range");

endmodule
